// ===== rtl/set_assoc_cache_miss_classifier_assert.svh =====
// Assertion macros used by the checker of the miss classifier.
// Depends on nothing; included by the checker module.
`ifndef SET_ASSOC_CACHE_MISS_CLASSIFIER_ASSERT_SVH
`define SET_ASSOC_CACHE_MISS_CLASSIFIER_ASSERT_SVH
// Check that a property holds on every rising clock edge outside reset.
`define SACMC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Check an implication from one cycle to the next.
`define SACMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/sacmc_pkg.sv =====
// Shared types and constants for the set-associative miss classifier.
// No dependencies.
`timescale 1ns / 1ps
package sacmc_pkg;
    localparam int MAX_SETS = 256;
    localparam int MAX_WAYS = 8;
    localparam int SET_W = $clog2(MAX_SETS);
    localparam int WAY_W = $clog2(MAX_WAYS);
    localparam int SETS_CFG_W = 9;
    localparam int WAYS_CFG_W = 4;
    localparam int ENTRY_W = SET_W + WAY_W;
    localparam int ADDR_W = 32;
    localparam int CNT_W = 32;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    localparam logic [1:0] KIND_HIT  = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_CONF = 2'd2;
    localparam logic [1:0] KIND_CAP  = 2'd3;

    localparam logic [1:0] REG_SETS = 2'd0;
    localparam logic [1:0] REG_WAYS = 2'd1;
    localparam logic [1:0] REG_SEED = 2'd2;

    // Divider control from the sequencer toward the divider.
    typedef struct packed {
        logic start;
        logic [ADDR_W-1:0] dividend;
        logic [SETS_CFG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [SETS_CFG_W-1:0] rem;
    } t_div_rsp;
endpackage

// ===== rtl/sacmc_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sacmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Read one entry per cycle, and write it as well when write is enabled.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/sacmc_div.sv =====
// Restoring remainder unit: one quotient bit per cycle.
// Depends on sacmc_pkg.
`timescale 1ns / 1ps
module sacmc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sacmc_pkg::t_div_req i_req,
    output sacmc_pkg::t_div_rsp o_rsp
);
    logic [sacmc_pkg::ADDR_W-1:0] r_num;
    logic [sacmc_pkg::SETS_CFG_W-1:0] r_den;
    logic [sacmc_pkg::SETS_CFG_W:0] r_rem;
    logic [5:0] r_cnt;
    logic r_busy;
    logic r_done;
    logic [sacmc_pkg::SETS_CFG_W:0] n_shift;

    assign n_shift = {r_rem[sacmc_pkg::SETS_CFG_W-1:0], r_num[sacmc_pkg::ADDR_W-1]};

    // Shift in one dividend bit and subtract when it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_rem  <= '0;
                r_cnt  <= 6'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num <= {r_num[sacmc_pkg::ADDR_W-2:0], 1'b0};
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                end else begin
                    r_rem <= n_shift;
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(sacmc_pkg::ADDR_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem[sacmc_pkg::SETS_CFG_W-1:0];
endmodule

// ===== rtl/set_assoc_cache_miss_classifier.sv =====
// A hit walks the ways up to the matching one; a miss walks all ways and fills an
// empty way if there is one, else a random pick runs the shared remainder unit again.
// One item at a time: input reopens in the idle state after the result transfer.
// Reset is synchronous, active low: registers return to 64 sets, one way, seed 1 and
// counters clear at once; a pass over all sets then clears the valid RAM, input not ready.
`timescale 1ns / 1ps
module set_assoc_cache_miss_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // [31:0] address
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] hit, [2:1] miss_kind, [34:3] hit_total, [66:35] miss_total,
    // [98:67] compulsory_total, [130:99] conflict_total, [162:131] capacity_total
    output logic [167:0] m_axis_tdata
);
    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_DIV   = 9'b000000100,
        ST_READ  = 9'b000001000,
        ST_CMP   = 9'b000010000,
        ST_DEC   = 9'b000100000,
        ST_PICK  = 9'b001000000,
        ST_WRITE = 9'b010000000,
        ST_OUT   = 9'b100000000
    } t_state;

    t_state r_state;
    logic [sacmc_pkg::SETS_CFG_W-1:0] r_set_cfg;
    logic [sacmc_pkg::WAYS_CFG_W-1:0] r_way_cfg;
    logic [15:0] r_seed;
    logic [15:0] r_lfsr;
    logic [sacmc_pkg::ADDR_W-1:0] r_addr;
    logic [sacmc_pkg::SET_W-1:0] r_set;
    logic [sacmc_pkg::SET_W-1:0] r_clr;
    logic [sacmc_pkg::WAY_W:0] r_way;
    logic [sacmc_pkg::WAY_W-1:0] r_victim;
    logic [sacmc_pkg::CNT_W-1:0] r_cnt [5];
    logic r_hit;
    logic [1:0] r_kind;

    logic [sacmc_pkg::SETS_CFG_W-1:0] eff_sets;
    logic [sacmc_pkg::WAY_W:0] eff_ways;
    sacmc_pkg::t_div_req div_req;
    sacmc_pkg::t_div_rsp div_rsp;
    logic ram_we;
    logic [sacmc_pkg::ENTRY_W-1:0] ram_addr;
    logic [sacmc_pkg::ADDR_W-1:0] ram_rdata;
    logic [sacmc_pkg::MAX_WAYS-1:0] set_valid;
    logic vld_we;
    logic [sacmc_pkg::SET_W-1:0] vld_addr;
    logic [sacmc_pkg::MAX_WAYS-1:0] vld_wdata;
    logic [sacmc_pkg::MAX_WAYS-1:0] victim_bit;
    logic [sacmc_pkg::MAX_WAYS-1:0] way_mask;
    logic [sacmc_pkg::WAY_W-1:0] free_way;
    logic has_free;
    logic pick_start;
    logic [15:0] n_lfsr;
    logic cfg_wr;
    logic [1:0] cfg_idx;
    logic in_acc;

    // Clamp configured counts to the supported range.
    always_comb begin
        if (r_set_cfg == '0) begin
            eff_sets = 9'd1;
        end else if (r_set_cfg > 9'(sacmc_pkg::MAX_SETS)) begin
            eff_sets = 9'(sacmc_pkg::MAX_SETS);
        end else begin
            eff_sets = r_set_cfg;
        end
        if (r_way_cfg == '0) begin
            eff_ways = 4'd1;
        end else if (r_way_cfg > 4'(sacmc_pkg::MAX_WAYS)) begin
            eff_ways = 4'(sacmc_pkg::MAX_WAYS);
        end else begin
            eff_ways = r_way_cfg;
        end
    end

    // Galois step of the replacement generator.
    always_comb begin
        n_lfsr = {1'b0, r_lfsr[15:1]} ^ (r_lfsr[0] ? sacmc_pkg::LFSR_TAPS : 16'h0);
        if (n_lfsr == 16'h0) begin
            n_lfsr = 16'h1;
        end
    end

    // Mask the ways in use and find the lowest empty one.
    always_comb begin
        way_mask = '0;
        free_way = '0;
        for (int w = sacmc_pkg::MAX_WAYS - 1; w >= 0; w--) begin
            if ((sacmc_pkg::WAY_W + 1)'(w) < eff_ways) begin
                way_mask[w] = 1'b1;
                if (!set_valid[w]) begin
                    free_way = sacmc_pkg::WAY_W'(w);
                end
            end
        end
    end

    assign has_free = |(way_mask & ~set_valid);

    always_comb begin
        victim_bit = '0;
        victim_bit[r_victim] = 1'b1;
    end

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);

    // Register readback.
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            sacmc_pkg::REG_SETS: prdata = 32'(r_set_cfg);
            sacmc_pkg::REG_WAYS: prdata = 32'(r_way_cfg);
            sacmc_pkg::REG_SEED: prdata = 32'(r_seed);
            default:             prdata = '0;
        endcase
    end

    // Share the remainder unit between the set index and the random way pick.
    assign pick_start       = (r_state == ST_DEC) && !r_hit && !has_free;
    assign div_req.start    = in_acc || pick_start;
    assign div_req.dividend = pick_start ? 32'(n_lfsr) : s_axis_tdata;
    assign div_req.divisor  = pick_start ? 9'(eff_ways) : eff_sets;

    sacmc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign ram_we   = (r_state == ST_WRITE);
    assign ram_addr = (r_state == ST_WRITE) ? {r_set, r_victim}
                                            : {r_set, r_way[sacmc_pkg::WAY_W-1:0]};

    sacmc_ram #(
        .WIDTH(sacmc_pkg::ADDR_W),
        .DEPTH(sacmc_pkg::MAX_SETS * sacmc_pkg::MAX_WAYS)
    ) u_tags (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_addr),
        .o_rdata(ram_rdata)
    );

    // Valid row per set: cleared after reset, set on a fill, read at the current set.
    assign vld_we    = (r_state == ST_CLEAR) || (r_state == ST_WRITE);
    assign vld_addr  = (r_state == ST_CLEAR) ? r_clr : r_set;
    assign vld_wdata = (r_state == ST_CLEAR) ? '0 : (set_valid | victim_bit);

    sacmc_ram #(
        .WIDTH(sacmc_pkg::MAX_WAYS),
        .DEPTH(sacmc_pkg::MAX_SETS)
    ) u_valid (
        .i_clk  (i_clk),
        .i_we   (vld_we),
        .i_addr (vld_addr),
        .i_wdata(vld_wdata),
        .o_rdata(set_valid)
    );

    // Sequencer: clear valid RAM, divide, walk the ways, classify, pick, write back, hold the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_set_cfg <= 9'd64;
            r_way_cfg <= 4'd1;
            r_seed    <= 16'd1;
            r_lfsr    <= 16'd1;
            for (int c = 0; c < 5; c++) begin
                r_cnt[c] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    sacmc_pkg::REG_SETS: r_set_cfg <= pwdata[8:0];
                    sacmc_pkg::REG_WAYS: r_way_cfg <= pwdata[3:0];
                    sacmc_pkg::REG_SEED: begin
                        r_seed <= pwdata[15:0];
                        r_lfsr <= (pwdata[15:0] == 16'h0) ? 16'h1 : pwdata[15:0];
                    end
                    default: ;
                endcase
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        r_addr  <= s_axis_tdata;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_set   <= div_rsp.rem[sacmc_pkg::SET_W-1:0];
                        r_way   <= '0;
                        r_hit   <= 1'b0;
                        r_state <= ST_READ;
                    end
                end
                ST_READ: r_state <= ST_CMP;
                ST_CMP: begin
                    if (set_valid[r_way[sacmc_pkg::WAY_W-1:0]] && ram_rdata == r_addr) begin
                        r_hit   <= 1'b1;
                        r_state <= ST_DEC;
                    end else if (r_way + 1'b1 == eff_ways) begin
                        r_state <= ST_DEC;
                    end else begin
                        r_way   <= r_way + 1'b1;
                        r_state <= ST_READ;
                    end
                end
                ST_DEC: begin
                    if (r_hit) begin
                        r_kind <= sacmc_pkg::KIND_HIT;
                        if (r_cnt[0] != '1) r_cnt[0] <= r_cnt[0] + 1'b1;
                        r_state <= ST_OUT;
                    end else begin
                        if (r_cnt[1] != '1) r_cnt[1] <= r_cnt[1] + 1'b1;
                        // A set is touched once any way was filled; one set, once its last way was.
                        if (!(|set_valid) || (eff_sets == 9'd1 &&
                                !set_valid[eff_ways[sacmc_pkg::WAY_W-1:0] - 1'b1])) begin
                            r_kind <= sacmc_pkg::KIND_COMP;
                            if (r_cnt[2] != '1) r_cnt[2] <= r_cnt[2] + 1'b1;
                        end else if (eff_sets == 9'd1) begin
                            r_kind <= sacmc_pkg::KIND_CAP;
                            if (r_cnt[4] != '1) r_cnt[4] <= r_cnt[4] + 1'b1;
                        end else begin
                            r_kind <= sacmc_pkg::KIND_CONF;
                            if (r_cnt[3] != '1) r_cnt[3] <= r_cnt[3] + 1'b1;
                        end
                        // Pick first empty way, else advance the generator and reduce it.
                        if (has_free) begin
                            r_victim <= free_way;
                            r_state  <= ST_WRITE;
                        end else begin
                            r_lfsr  <= n_lfsr;
                            r_state <= ST_PICK;
                        end
                    end
                end
                ST_PICK: begin
                    if (div_rsp.done) begin
                        r_victim <= div_rsp.rem[sacmc_pkg::WAY_W-1:0];
                        r_state  <= ST_WRITE;
                    end
                end
                ST_WRITE: r_state <= ST_OUT;
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {5'd0, r_cnt[4], r_cnt[3], r_cnt[2], r_cnt[1], r_cnt[0],
                           r_kind, r_hit};
endmodule

// ===== rtl/sacmc_checker.sv =====
// Port-level checks of the miss classifier handshakes and results.
// Depends on set_assoc_cache_miss_classifier_assert.svh; bound to the top level.
`timescale 1ns / 1ps
`include "set_assoc_cache_miss_classifier_assert.svh"
module sacmc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [167:0] m_axis_tdata
);
    // One item in flight: no input while a result waits.
    `SACMC_ASSERT(a_one_in_flight, i_clk, i_rst_n, !(m_axis_tvalid && s_axis_tready))
    // Hit flag agrees with the kind code.
    `SACMC_ASSERT(a_hit_kind, i_clk, i_rst_n,
        !m_axis_tvalid || (m_axis_tdata[0] == (m_axis_tdata[2:1] == 2'd0)))
    // An accepted item closes the input directly after its transfer.
    `SACMC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n,
        s_axis_tvalid && s_axis_tready, !s_axis_tready)
    // A stalled result holds.
    `SACMC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind set_assoc_cache_miss_classifier sacmc_checker u_sacmc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
